FILE: rtl/core/lkv_pkg.sv
// lkv_pkg: shared sizes, operation codes and the search request token
// for the linear key-value table; no dependencies
package lkv_pkg;

	localparam int DEPTH       = 16;
	localparam int KEY_WIDTH   = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W       = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_GET   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	// request token walking down the row of entry cells
	typedef struct packed {
		logic                   valid;
		logic                   is_set;
		logic [KEY_WIDTH-1:0]   key;
		logic [VALUE_WIDTH-1:0] value;
		logic [CNT_W-1:0]       remaining;
		logic                   found;
		logic                   appended;
		logic [VALUE_WIDTH-1:0] rd;
	} token_t;

endpackage

FILE: rtl/core/lkv_cell.sv
// lkv_cell: one table entry (key and value) that checks the passing request,
// updates or appends itself and hands the request on; depends on lkv_pkg
module lkv_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  lkv_pkg::token_t tok_in,
	output lkv_pkg::token_t tok_out
);

	logic [lkv_pkg::KEY_WIDTH-1:0]   key_q;
	logic [lkv_pkg::VALUE_WIDTH-1:0] value_q;
	lkv_pkg::token_t                 tok_q;
	lkv_pkg::token_t                 tok_d;
	logic                            live;
	logic                            match;
	logic                            append;

	assign live   = tok_in.remaining != '0;
	assign match  = tok_in.valid && live && !tok_in.found && (key_q == tok_in.key);
	assign append = tok_in.valid && !live && !tok_in.found && !tok_in.appended;

	always_comb begin
		tok_d = tok_in;
		tok_d.remaining = live ? tok_in.remaining - 1'b1 : '0;
		if (match) begin
			tok_d.found = 1'b1;
			if (!tok_in.is_set) begin
				tok_d.rd = value_q;
			end
		end
		if (append) begin
			tok_d.appended = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	// entry storage, undefined until first written
	always_ff @(posedge clk) begin
		if (append) begin
			key_q   <= tok_in.key;
			value_q <= tok_in.value;
		end else if (match && tok_in.is_set) begin
			value_q <= tok_in.value;
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: rtl/core/lkv_chain.sv
// lkv_chain: row of DEPTH entry cells, the request passes one cell per cycle
// depends on lkv_pkg and lkv_cell
module lkv_chain (
	input  logic            clk,
	input  logic            arst_n,
	input  lkv_pkg::token_t tok_in,
	output lkv_pkg::token_t tok_out
);

	lkv_pkg::token_t tok [0:lkv_pkg::DEPTH];

	assign tok[0] = tok_in;

	for (genvar g = 0; g < lkv_pkg::DEPTH; g++) begin : g_row
		lkv_cell u_entry (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1])
		);
	end

	assign tok_out = tok[lkv_pkg::DEPTH];

endmodule

FILE: rtl/core/linear_key_value_table.sv
// linear_key_value_table: top level, request control, entry count and result
// registers around the cell row; depends on lkv_pkg and lkv_chain
//
// channel   direction  handshake               payload
// request   in         start & !busy           operation, lookup_key, new_value
// result    out        done (one cycle)        read_value, hit, entry_count, full_drop
//
// set and get pass through one launch register, one register per entry cell
// and one result register from request to done. clear and the unused code
// raise done in the next cycle. busy is high while a set or get searches and
// is low again in the done cycle. arst_n empties the table; entry contents
// are not cleared. results cannot be stalled.
module linear_key_value_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [31:0] lookup_key,
	input  logic [31:0] new_value,
	output logic        done,
	output logic [31:0] read_value,
	output logic        hit,
	output logic [4:0]  entry_count,
	output logic        full_drop
);

	lkv_pkg::state_t                 state_q;
	lkv_pkg::state_t                 state_d;
	lkv_pkg::op_t                    op;
	lkv_pkg::token_t                 launch_q;
	lkv_pkg::token_t                 launch_d;
	lkv_pkg::token_t                 chain_out;
	logic [lkv_pkg::CNT_W-1:0]       count_q;
	logic [lkv_pkg::CNT_W-1:0]       count_d;
	logic                            accept;
	logic                            finish_now;
	logic                            finish_search;
	logic [63:0]                     key_ext;
	logic [63:0]                     value_ext;
	logic [63:0]                     rd_ext;
	logic [63:0]                     cnt_ext;
	logic                            done_q;
	logic [31:0]                     read_value_q;
	logic                            hit_q;
	logic [4:0]                      entry_count_q;
	logic                            full_drop_q;

	assign op        = lkv_pkg::op_t'(operation);
	assign accept    = start && !busy;
	assign key_ext   = 64'(lookup_key);
	assign value_ext = 64'(new_value);
	assign rd_ext    = 64'(chain_out.rd);
	assign cnt_ext   = 64'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		finish_now    = 1'b0;
		finish_search = 1'b0;
		count_d       = count_q;
		launch_d      = '0;
		unique case (state_q)
			lkv_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (op)
						lkv_pkg::OP_SET, lkv_pkg::OP_GET: begin
							launch_d.valid     = 1'b1;
							launch_d.is_set    = (op == lkv_pkg::OP_SET);
							launch_d.key       = key_ext[lkv_pkg::KEY_WIDTH-1:0];
							launch_d.value     = (op == lkv_pkg::OP_SET) ?
								value_ext[lkv_pkg::VALUE_WIDTH-1:0] : '0;
							launch_d.remaining = count_q;
							state_d            = lkv_pkg::ST_SEARCH;
						end
						lkv_pkg::OP_CLEAR: begin
							finish_now = 1'b1;
							count_d    = '0;
						end
						lkv_pkg::OP_NOP: begin
							finish_now = 1'b1;
						end
						default: begin
							finish_now = 1'b1;
						end
					endcase
				end
			end
			lkv_pkg::ST_SEARCH: begin
				if (chain_out.valid) begin
					finish_search = 1'b1;
					count_d       = count_q + lkv_pkg::CNT_W'(chain_out.appended);
					state_d       = lkv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lkv_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			launch_q <= launch_d;
			count_q  <= count_d;
			done_q   <= finish_now || finish_search;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_now || finish_search) begin
			read_value_q  <= finish_search ? rd_ext[31:0] : 32'd0;
			hit_q         <= finish_search && chain_out.found;
			full_drop_q   <= finish_search && !chain_out.found && !chain_out.appended;
			entry_count_q <= cnt_ext[4:0];
		end
	end

	lkv_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.tok_in  (launch_q),
		.tok_out (chain_out)
	);

	assign busy        = (state_q != lkv_pkg::ST_IDLE);
	assign done        = done_q;
	assign read_value  = read_value_q;
	assign hit         = hit_q;
	assign entry_count = entry_count_q;
	assign full_drop   = full_drop_q;

endmodule

FILE: sim/linear_key_value_table_test.sv
// linear_key_value_table_test: self-checking bench for the key-value table; a mirror of
// the table predicts each result and a small scoreboard compares results as they arrive
// depends on lkv_pkg and linear_key_value_table
`timescale 1ns / 100ps

module linear_key_value_table_test;

	typedef struct packed {
		logic [31:0] read_value;
		logic        hit;
		logic [4:0]  entry_count;
		logic        full_drop;
	} table_result_t;

	class table_scoreboard;
		logic [lkv_pkg::KEY_WIDTH-1:0]   mirror_keys [lkv_pkg::DEPTH];
		logic [lkv_pkg::VALUE_WIDTH-1:0] mirror_values [lkv_pkg::DEPTH];
		int                              mirror_count;
		table_result_t                   pending [$];
		int                              mismatches;
		int                              num_checked;
		int                              num_hits;
		int                              num_drops;
		int                              num_full;

		function new();
			mirror_count = 0;
			mismatches   = 0;
			num_checked  = 0;
			num_hits     = 0;
			num_drops    = 0;
			num_full     = 0;
		endfunction

		// mirror one accepted request and queue the result it must produce
		function void note_request(lkv_pkg::op_t op, logic [31:0] key, logic [31:0] value);
			table_result_t want;
			int            slot;
			want = '0;
			slot = -1;
			if (op == lkv_pkg::OP_SET || op == lkv_pkg::OP_GET) begin
				for (int i = 0; i < mirror_count; i++) begin
					if (slot < 0 && mirror_keys[i] == key)
						slot = i;
				end
				if (slot >= 0) begin
					want.hit = 1'b1;
					if (op == lkv_pkg::OP_SET)
						mirror_values[slot] = value;
					else
						want.read_value = mirror_values[slot];
				end else if (mirror_count < lkv_pkg::DEPTH) begin
					mirror_keys[mirror_count]   = key;
					mirror_values[mirror_count] = (op == lkv_pkg::OP_SET) ? value : '0;
					mirror_count++;
				end else begin
					want.full_drop = 1'b1;
				end
			end else if (op == lkv_pkg::OP_CLEAR) begin
				mirror_count = 0;
			end
			want.entry_count = 5'(mirror_count);
			if (want.hit)
				num_hits++;
			if (want.full_drop)
				num_drops++;
			if (mirror_count == lkv_pkg::DEPTH)
				num_full++;
			pending.push_back(want);
		endfunction

		function void check_result(table_result_t got);
			table_result_t want;
			if (pending.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected result: value %h hit %b count %0d drop %b",
						$time, got.read_value, got.hit, got.entry_count, got.full_drop);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			num_checked++;
			if (got.read_value !== want.read_value || got.hit !== want.hit ||
				got.entry_count !== want.entry_count || got.full_drop !== want.full_drop) begin
				if (mismatches < 10) begin
					$display("%0t: mismatch: expected value %h hit %b count %0d drop %b",
						$time, want.read_value, want.hit, want.entry_count,
						want.full_drop);
					$display("%0t:                got value %h hit %b count %0d drop %b",
						$time, got.read_value, got.hit, got.entry_count,
						got.full_drop);
				end
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  operation = lkv_pkg::OP_NOP;
	logic [31:0] lookup_key = '0;
	logic [31:0] new_value = '0;
	logic        busy;
	logic        done;
	logic [31:0] read_value;
	logic        hit;
	logic [4:0]  entry_count;
	logic        full_drop;

	table_scoreboard table_log = new();
	int              num_requests = 0;
	logic [31:0]     key_pool [24];

	linear_key_value_table DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.lookup_key  (lookup_key),
		.new_value   (new_value),
		.done        (done),
		.read_value  (read_value),
		.hit         (hit),
		.entry_count (entry_count),
		.full_drop   (full_drop)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			table_log.check_result({read_value, hit, entry_count, full_drop});
	end

	task automatic issue_request(lkv_pkg::op_t op, logic [31:0] key, logic [31:0] value,
		int idle_pct);
		start      <= 1'b1;
		operation  <= op;
		lookup_key <= key;
		new_value  <= value;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		table_log.note_request(op, key, value);
		num_requests++;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic random_requests(int count, int idle_pct);
		int           pick;
		lkv_pkg::op_t op;
		logic [31:0]  key;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 46)
				op = lkv_pkg::OP_SET;
			else if (pick < 92)
				op = lkv_pkg::OP_GET;
			else if (pick < 96)
				op = lkv_pkg::OP_CLEAR;
			else
				op = lkv_pkg::OP_NOP;
			if ($urandom_range(99) < 88)
				key = key_pool[$urandom_range(23)];
			else
				key = $urandom;
			issue_request(op, key, $urandom, idle_pct);
		end
	endtask

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		for (int i = 0; i < 24; i++)
			key_pool[i] = $urandom;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, hits, field extremes, unused code, clear
		issue_request(lkv_pkg::OP_GET, 32'h1234_5678, 32'hFFFF_FFFF, 0);
		issue_request(lkv_pkg::OP_GET, 32'h1234_5678, 32'h0, 0);
		issue_request(lkv_pkg::OP_SET, 32'h0, 32'hFFFF_FFFF, 0);
		issue_request(lkv_pkg::OP_SET, 32'hFFFF_FFFF, 32'h0, 0);
		issue_request(lkv_pkg::OP_GET, 32'h0, 32'h0, 0);
		issue_request(lkv_pkg::OP_SET, 32'h1234_5678, 32'hA5A5_5A5A, 0);
		issue_request(lkv_pkg::OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		issue_request(lkv_pkg::OP_CLEAR, 32'h0, 32'h0, 0);
		// fill the table, then miss on a full table with set and get
		for (int i = 0; i < lkv_pkg::DEPTH; i++)
			issue_request(lkv_pkg::OP_SET, 32'h1111_1111 * i, $urandom, 0);
		issue_request(lkv_pkg::OP_SET, 32'h8000_0001, 32'h7777_7777, 0);
		issue_request(lkv_pkg::OP_GET, 32'h8000_0001, 32'h0, 0);
		issue_request(lkv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0, 0);
		issue_request(lkv_pkg::OP_NOP, 32'h0, 32'h0, 0);

		random_requests(530, 8);
		random_requests(530, 45);
		random_requests(530, 0);
		start <= 1'b0;

		while (table_log.pending.size() != 0)
			@(posedge clk);
		repeat (lkv_pkg::DEPTH + 4) @(posedge clk);

		$display("requests sent: %0d, results checked: %0d, mismatches: %0d",
			num_requests, table_log.num_checked, table_log.mismatches);
		$display("key hits: %0d, appends dropped on a full table: %0d, results at full: %0d",
			table_log.num_hits, table_log.num_drops, table_log.num_full);
		if (table_log.mismatches == 0 && table_log.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
